[rtl/papij_pkg.sv]
// Package for the planar arm PID block: item types, state codes, constants, arctangent table.
`timescale 1ns / 1ps
package papij_pkg;

    // Default number of CORDIC iterations
    localparam int CORDIC_STEPS_DEF = 16;

    // Register indexes
    localparam logic [2:0] CFG_LINK1_LENGTH    = 3'd0;
    localparam logic [2:0] CFG_LINK2_LENGTH    = 3'd1;
    localparam logic [2:0] CFG_PROP_GAIN       = 3'd2;
    localparam logic [2:0] CFG_INTEGRAL_GAIN   = 3'd3;
    localparam logic [2:0] CFG_DERIV_GAIN      = 3'd4;
    localparam logic [2:0] CFG_OUTPUT_GAIN     = 3'd5;
    localparam logic [2:0] CFG_SAMPLE_TIME     = 3'd6;
    localparam logic [2:0] CFG_INV_SAMPLE_TIME = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_LINK1_LENGTH    = 16'd19661;
    localparam logic [15:0] RST_LINK2_LENGTH    = 16'd13107;
    localparam logic [23:0] RST_PROP_GAIN       = 24'd983040;
    localparam logic [23:0] RST_INTEGRAL_GAIN   = 24'd6554;
    localparam logic [23:0] RST_DERIV_GAIN      = 24'd655;
    localparam logic [23:0] RST_OUTPUT_GAIN     = 24'd655360;
    localparam logic [15:0] RST_SAMPLE_TIME     = 16'd1114;
    localparam logic [27:0] RST_INV_SAMPLE_TIME = 28'd3855059;

    // Angle constants, Q.28 radians
    localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
    localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
    localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;

    typedef struct packed {
        logic signed [15:0] joint1_angle;
        logic signed [15:0] joint2_angle;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive_joint1;
        logic signed [31:0] drive_joint2;
        logic signed [15:0] tip_x;
        logic signed [15:0] tip_y;
        logic               singular;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORD,
        S_MUL,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    // Multiply steps of the sequencer, in execution order
    typedef enum logic [4:0] {
        OP_TIP_XA, OP_TIP_XB, OP_TIP_YA, OP_TIP_YB,
        OP_DER_X, OP_INT_X, OP_KP_X, OP_KI_X, OP_KD_X,
        OP_DER_Y, OP_INT_Y, OP_KP_Y, OP_KI_Y, OP_KD_Y,
        OP_DET_A, OP_DET_B,
        OP_N1_A, OP_N1_B, OP_N1_ST, OP_N1_OG,
        OP_N2_A, OP_N2_B, OP_N2_ST, OP_N2_OG
    } t_op;

    // CORDIC arctangent of 2^-i, Q.28
    function automatic logic [27:0] f_atan(input logic [4:0] i);
        logic [27:0] v;
        unique case (i)
            5'd0:  v = 28'd210828714;
            5'd1:  v = 28'd124459457;
            5'd2:  v = 28'd65760959;
            5'd3:  v = 28'd33381290;
            5'd4:  v = 28'd16755422;
            5'd5:  v = 28'd8385879;
            5'd6:  v = 28'd4193963;
            5'd7:  v = 28'd2097109;
            5'd8:  v = 28'd1048571;
            5'd9:  v = 28'd524287;
            5'd10: v = 28'd262144;
            5'd11: v = 28'd131072;
            5'd12: v = 28'd65536;
            5'd13: v = 28'd32768;
            5'd14: v = 28'd16384;
            5'd15: v = 28'd8192;
            5'd16: v = 28'd4096;
            5'd17: v = 28'd2048;
            5'd18: v = 28'd1024;
            5'd19: v = 28'd512;
            5'd20: v = 28'd256;
            5'd21: v = 28'd128;
            5'd22: v = 28'd64;
            5'd23: v = 28'd32;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/planar_arm_pid_inverse_jacobian.sv]
// Top level: two-link planar arm Cartesian PID with inverse Jacobian drive mapping.
`timescale 1ns / 1ps
// One item in, one result out, one item at a time. An accepted item runs two CORDIC
// passes of CORDIC_STEPS iterations each, a tip and Jacobian setup step, 24 products
// on one bit-serial shift-add multiplier (one multiplier bit per cycle) and two
// restoring divisions, one quotient bit per cycle, then the result is loaded into the
// output register once that register is empty or not stalled. Most of an item's time
// goes to the multiplier. A finished result waits in the output register; the next item
// is taken once the sequencer is idle again.
module planar_arm_pid_inverse_jacobian #(
    parameter int CORDIC_STEPS = papij_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  papij_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output papij_pkg::t_out_item o_item,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [27:0]          i_cfg_data
);
    import papij_pkg::*;

    localparam int CI_W   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int B_W    = 25;
    localparam int MUL_WB = B_W + 1;

    // Rounding shift and saturation helpers
    function automatic logic signed [63:0] f_rnd(input logic signed [63:0] v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = 32'(v);
        return r;
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) r = 16'sh7FFF;
        else if (v < -64'sd32768) r = 16'sh8000;
        else r = 16'(v);
        return r;
    endfunction

    // Fold an angle into [-pi/2, pi/2]; MSB is the flip flag
    function automatic logic [34:0] f_fold(input logic signed [33:0] z);
        logic signed [33:0] t;
        logic               f;
        t = z;
        f = 1'b0;
        if (t > ANG_PI) t = t - ANG_TWO_PI;
        else if (t < -ANG_PI) t = t + ANG_TWO_PI;
        if (t > ANG_HALF_PI) begin
            t = t - ANG_PI;
            f = 1'b1;
        end else if (t < -ANG_HALF_PI) begin
            t = t + ANG_PI;
            f = 1'b1;
        end
        return {f, t};
    endfunction

    t_state r_state, n_state;
    t_op    r_op, n_op;

    // Configuration registers
    logic [15:0] r_l1, r_l2, r_st;
    logic [23:0] r_kp, r_ki, r_kd, r_og;
    logic [27:0] r_ist;

    // Item and PID state
    logic signed [15:0] r_tx, r_ty;
    logic signed [16:0] r_q12;
    logic signed [16:0] r_prevx, r_prevy, r_ex, r_ey;
    logic signed [31:0] r_intx, r_inty, r_der, r_ddx, r_ddy, r_d1, r_d2;

    // CORDIC
    logic signed [31:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic               r_flip, r_cpass;
    logic [CI_W-1:0]    r_ci;
    logic signed [31:0] r_c1, r_s1, r_c12, r_s12;

    // Multiplier and intermediates
    logic [4:0]         r_mcnt;
    logic signed [63:0] r_ma, r_acc, r_tmp, r_sum, r_m;
    logic [B_W-1:0]     r_mb;
    logic signed [47:0] r_sx, r_sy, r_det;
    logic signed [19:0] r_ja, r_jb, r_jc, r_jd;
    logic signed [15:0] r_tipx, r_tipy;

    // Divider
    logic [63:0] r_up;
    logic [47:0] r_ud;
    logic        r_neg;
    logic [48:0] r_rem;
    logic [30:0] r_dsh, r_dq;
    logic [5:0]  r_dcnt;

    logic      r_ovalid;
    t_out_item r_oitem;

    logic w_accept, w_cdone, w_mwb, w_ddone, w_oload;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_item   = r_oitem;

    // CORDIC step
    logic signed [31:0] w_shx, w_shy, w_nx, w_ny;
    logic signed [33:0] w_nz, w_atan;
    logic [34:0]        w_fold0, w_fold1;

    assign w_shx   = r_cx >>> r_ci;
    assign w_shy   = r_cy >>> r_ci;
    assign w_atan  = 34'(f_atan(5'(r_ci)));
    assign w_fold0 = f_fold(34'(i_item.joint1_angle) <<< 15);
    assign w_fold1 = f_fold(34'(r_q12) <<< 15);

    always_comb begin
        if (!r_cz[33]) begin
            w_nx = r_cx - w_shy;
            w_ny = r_cy + w_shx;
            w_nz = r_cz - w_atan;
        end else begin
            w_nx = r_cx + w_shy;
            w_ny = r_cy - w_shx;
            w_nz = r_cz + w_atan;
        end
    end

    assign w_cdone = (r_state == S_CORD) && (r_ci == CI_W'(CORDIC_STEPS - 1));

    // Error terms straight from the tip registers
    logic signed [16:0] w_ex, w_ey;
    logic signed [17:0] w_dex, w_dey;
    assign w_ex  = 17'(r_tx) - 17'(r_tipx);
    assign w_ey  = 17'(r_ty) - 17'(r_tipy);
    assign w_dex = 18'(w_ex) - 18'(r_prevx);
    assign w_dey = 18'(w_ey) - 18'(r_prevy);

    // Multiplier operand selection
    logic signed [63:0] w_opa;
    logic [B_W-1:0]     w_opb;
    always_comb begin
        w_opa = 64'sd0;
        w_opb = '0;
        unique case (r_op)
            OP_TIP_XA: begin w_opa = 64'(r_c1);  w_opb = B_W'(r_l1); end
            OP_TIP_XB: begin w_opa = 64'(r_c12); w_opb = B_W'(r_l2); end
            OP_TIP_YA: begin w_opa = 64'(r_s1);  w_opb = B_W'(r_l1); end
            OP_TIP_YB: begin w_opa = 64'(r_s12); w_opb = B_W'(r_l2); end
            OP_DER_X:  begin w_opa = 64'(r_ist); w_opb = B_W'(w_dex); end
            OP_INT_X:  begin w_opa = 64'(r_st);  w_opb = B_W'(r_ex); end
            OP_KP_X:   begin w_opa = 64'(r_kp);  w_opb = B_W'(r_ex); end
            OP_KI_X:   begin w_opa = 64'(r_intx); w_opb = B_W'(r_ki); end
            OP_KD_X:   begin w_opa = 64'(r_der); w_opb = B_W'(r_kd); end
            OP_DER_Y:  begin w_opa = 64'(r_ist); w_opb = B_W'(w_dey); end
            OP_INT_Y:  begin w_opa = 64'(r_st);  w_opb = B_W'(r_ey); end
            OP_KP_Y:   begin w_opa = 64'(r_kp);  w_opb = B_W'(r_ey); end
            OP_KI_Y:   begin w_opa = 64'(r_inty); w_opb = B_W'(r_ki); end
            OP_KD_Y:   begin w_opa = 64'(r_der); w_opb = B_W'(r_kd); end
            OP_DET_A:  begin w_opa = 64'(r_ja);  w_opb = B_W'(r_jd); end
            OP_DET_B:  begin w_opa = 64'(r_jb);  w_opb = B_W'(r_jc); end
            OP_N1_A:   begin w_opa = 64'(r_ddx); w_opb = B_W'(r_jd); end
            OP_N1_B:   begin w_opa = 64'(r_ddy); w_opb = B_W'(r_jb); end
            OP_N1_ST:  begin w_opa = r_m;        w_opb = B_W'(r_st); end
            OP_N1_OG:  begin w_opa = r_m;        w_opb = B_W'(r_og); end
            OP_N2_A:   begin w_opa = 64'(r_ddy); w_opb = B_W'(r_ja); end
            OP_N2_B:   begin w_opa = 64'(r_ddx); w_opb = B_W'(r_jc); end
            OP_N2_ST:  begin w_opa = r_m;        w_opb = B_W'(r_st); end
            OP_N2_OG:  begin w_opa = r_m;        w_opb = B_W'(r_og); end
            default:   begin w_opa = 64'sd0;     w_opb = '0; end
        endcase
    end

    assign w_mwb = (r_state == S_MUL) && (r_mcnt == 5'(MUL_WB));

    // Divider step
    logic [48:0] w_rinit, w_rsh;
    logic        w_qbit;
    logic [30:0] w_qn;
    logic        w_dearly;
    assign w_rinit  = r_up[63:15];
    assign w_rsh    = {r_rem[47:0], r_dsh[30]};
    assign w_qbit   = (w_rsh >= 49'(r_ud));
    assign w_qn     = {r_dq[29:0], w_qbit};
    assign w_dearly = (r_ud == 48'd0) || (w_rinit >= 49'(r_ud));
    assign w_ddone  = (r_state == S_DIV) &&
                      (((r_dcnt == 6'd0) && w_dearly) || (r_dcnt == 6'd31));

    assign w_oload = (r_state == S_OUT) && (!r_ovalid || !i_stall);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_TIP_XA;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_CORD;
            S_CORD: if (w_cdone && r_cpass) begin
                n_state = S_MUL;
                n_op    = OP_TIP_XA;
            end
            S_MUL: if (w_mwb) begin
                priority case (r_op)
                    OP_TIP_YB: begin
                        n_state = S_PREP;
                        n_op    = OP_DER_X;
                    end
                    OP_N1_OG, OP_N2_OG: n_state = S_DIV;
                    default: n_op = t_op'(r_op + 5'd1);
                endcase
            end
            S_PREP: n_state = S_MUL;
            S_DIV: if (w_ddone) begin
                if (r_op == OP_N1_OG) begin
                    n_state = S_MUL;
                    n_op    = OP_N2_A;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: if (w_oload) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1  <= RST_LINK1_LENGTH;
            r_l2  <= RST_LINK2_LENGTH;
            r_kp  <= RST_PROP_GAIN;
            r_ki  <= RST_INTEGRAL_GAIN;
            r_kd  <= RST_DERIV_GAIN;
            r_og  <= RST_OUTPUT_GAIN;
            r_st  <= RST_SAMPLE_TIME;
            r_ist <= RST_INV_SAMPLE_TIME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINK1_LENGTH:    r_l1  <= i_cfg_data[15:0];
                CFG_LINK2_LENGTH:    r_l2  <= i_cfg_data[15:0];
                CFG_PROP_GAIN:       r_kp  <= i_cfg_data[23:0];
                CFG_INTEGRAL_GAIN:   r_ki  <= i_cfg_data[23:0];
                CFG_DERIV_GAIN:      r_kd  <= i_cfg_data[23:0];
                CFG_OUTPUT_GAIN:     r_og  <= i_cfg_data[23:0];
                CFG_SAMPLE_TIME:     r_st  <= i_cfg_data[15:0];
                CFG_INV_SAMPLE_TIME: r_ist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // CORDIC iterations, joint 1 angle first, then the sum angle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci    <= '0;
            r_cpass <= 1'b0;
        end else if (w_accept) begin
            r_ci    <= '0;
            r_cpass <= 1'b0;
        end else if (r_state == S_CORD) begin
            if (w_cdone) begin
                r_ci    <= '0;
                r_cpass <= 1'b1;
            end else begin
                r_ci <= r_ci + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tx   <= i_item.target_x;
            r_ty   <= i_item.target_y;
            r_q12  <= 17'(i_item.joint1_angle) + 17'(i_item.joint2_angle);
            r_cx   <= CORDIC_GAIN;
            r_cy   <= 32'sd0;
            r_cz   <= w_fold0[33:0];
            r_flip <= w_fold0[34];
        end else if (r_state == S_CORD) begin
            if (w_cdone && !r_cpass) begin
                r_c1   <= r_flip ? -w_nx : w_nx;
                r_s1   <= r_flip ? -w_ny : w_ny;
                r_cx   <= CORDIC_GAIN;
                r_cy   <= 32'sd0;
                r_cz   <= w_fold1[33:0];
                r_flip <= w_fold1[34];
            end else begin
                if (w_cdone) begin
                    r_c12 <= r_flip ? -w_nx : w_nx;
                    r_s12 <= r_flip ? -w_ny : w_ny;
                end
                r_cx <= w_nx;
                r_cy <= w_ny;
                r_cz <= w_nz;
            end
        end
    end

    // Bit-serial multiplier: load, one multiplier bit per cycle, then write-back
    logic signed [63:0] w_madd;
    assign w_madd = r_mb[0] ? r_ma : 64'sd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
        end else if (r_state == S_MUL) begin
            r_mcnt <= w_mwb ? 5'd0 : r_mcnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            if (r_mcnt == 5'd0) begin
                r_ma  <= w_opa;
                r_mb  <= w_opb;
                r_acc <= 64'sd0;
            end else if (r_mcnt <= 5'(B_W)) begin
                // top multiplier bit carries negative weight
                r_acc <= (r_mcnt == 5'(B_W)) ? r_acc - w_madd : r_acc + w_madd;
                r_ma  <= r_ma <<< 1;
                r_mb  <= r_mb >> 1;
            end
        end
    end

    // Product write-back and PID state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prevx <= '0;
            r_prevy <= '0;
            r_intx  <= '0;
            r_inty  <= '0;
        end else if (w_mwb) begin
            unique case (r_op)
                OP_INT_X: begin
                    r_intx  <= f_sat32(64'(r_intx) + f_rnd(r_acc, 2));
                    r_prevx <= r_ex;
                end
                OP_INT_Y: begin
                    r_inty  <= f_sat32(64'(r_inty) + f_rnd(r_acc, 2));
                    r_prevy <= r_ey;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mwb) begin
            unique case (r_op)
                OP_TIP_XA, OP_TIP_YA, OP_DET_A, OP_N1_A, OP_N2_A: r_tmp <= r_acc;
                OP_TIP_XB: begin
                    r_sx <= 48'(r_tmp + r_acc);
                    r_jd <= 20'(f_rnd(r_acc, 28));
                end
                OP_TIP_YB: begin
                    r_sy <= 48'(r_tmp + r_acc);
                    r_jb <= 20'(f_rnd(-r_acc, 28));
                end
                OP_DER_X: begin
                    r_der <= f_sat32(f_rnd(r_acc, 14));
                    r_ex  <= w_ex;
                end
                OP_DER_Y: begin
                    r_der <= f_sat32(f_rnd(r_acc, 14));
                    r_ey  <= w_ey;
                end
                OP_INT_X, OP_INT_Y: ;
                OP_KP_X, OP_KP_Y: r_sum <= r_acc <<< 2;
                OP_KI_X, OP_KI_Y: r_sum <= r_sum + f_rnd(r_acc, 12);
                OP_KD_X: r_ddx <= f_sat32(f_rnd(r_sum + r_acc, 16));
                OP_KD_Y: r_ddy <= f_sat32(f_rnd(r_sum + r_acc, 16));
                OP_DET_B: r_det <= 48'(r_tmp - r_acc);
                OP_N1_B, OP_N2_B: r_m <= f_rnd(r_tmp - r_acc, 16);
                OP_N1_ST, OP_N2_ST: r_m <= f_rnd(r_acc, 16);
                OP_N1_OG, OP_N2_OG: begin
                    r_up  <= r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
                    r_ud  <= r_det[47] ? 48'(-r_det) : 48'(r_det);
                    r_neg <= r_acc[63] ^ r_det[47];
                end
                default: ;
            endcase
        end
    end

    // Tip position and remaining Jacobian entries
    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_tipx <= f_sat16(f_rnd(64'(r_sx), 30));
            r_tipy <= f_sat16(f_rnd(64'(r_sy), 30));
            r_ja   <= 20'(f_rnd(-64'(r_sy), 28));
            r_jc   <= 20'(f_rnd(64'(r_sx), 28));
        end
    end

    // Restoring divider, saturation check first, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (r_state == S_DIV) begin
            r_dcnt <= w_ddone ? 6'd0 : r_dcnt + 6'd1;
        end
    end

    logic signed [31:0] w_drv;
    always_comb begin
        if (r_dcnt == 6'd0) begin
            if (r_ud == 48'd0) w_drv = 32'sd0;
            else w_drv = r_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            w_drv = r_neg ? -32'(w_qn) : 32'(w_qn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV) begin
            if (r_dcnt == 6'd0) begin
                r_rem <= w_rinit;
                r_dsh <= {r_up[14:0], 16'd0};
                r_dq  <= '0;
            end else begin
                r_rem <= w_qbit ? w_rsh - 49'(r_ud) : w_rsh;
                r_dsh <= r_dsh << 1;
                r_dq  <= w_qn;
            end
            if (w_ddone) begin
                if (r_op == OP_N1_OG) r_d1 <= w_drv;
                else r_d2 <= w_drv;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oload) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_oitem.drive_joint1 <= r_d1;
            r_oitem.drive_joint2 <= r_d2;
            r_oitem.tip_x        <= r_tipx;
            r_oitem.tip_y        <= r_tipy;
            r_oitem.singular     <= (r_det == 48'sd0);
        end
    end

endmodule

[rtl/papij_checker.sv]
// Port-level checker for the planar arm PID block, with its bind.
`timescale 1ns / 1ps
module papij_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input papij_pkg::t_out_item o_item
);
    import papij_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    // An accepted item makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("no busy after accepted item");

    // Singular results carry zero drives
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.singular |->
            (o_item.drive_joint1 == 32'sd0) && (o_item.drive_joint2 == 32'sd0))
        else $error("singular result with nonzero drive");

    // Reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind planar_arm_pid_inverse_jacobian papij_checker u_papij_checker (.*);
